>>> rtl/wiep_pkg.sv
// ----------------------------------------------------------------------------
// wiep_pkg
// Shared types and constants for the information element parser.
// ----------------------------------------------------------------------------
package wiep_pkg;

  localparam int MAX_REGION_BYTES = 4096;
  localparam int POS_W            = $clog2(MAX_REGION_BYTES + 1);
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int RATE_BITS        = 126;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [11:0]      ofs_t;

  localparam pos_t REGION_LIMIT = pos_t'(MAX_REGION_BYTES);

  // element ids
  localparam logic [7:0] EID_SSID      = 8'd0;
  localparam logic [7:0] EID_RATES     = 8'd1;
  localparam logic [7:0] EID_CHANNEL   = 8'd3;
  localparam logic [7:0] EID_RSN       = 8'd48;
  localparam logic [7:0] EID_EXT_RATES = 8'd50;

  // length limits
  localparam logic [7:0] SSID_MAX_LEN  = 8'd32;
  localparam logic [7:0] RATES_MAX_LEN = 8'd8;
  localparam logic [7:0] CHANNEL_LEN   = 8'd1;

  // rate values that carry no bit
  localparam logic [6:0] RATE_SKIP_LO = 7'd126;
  localparam logic [6:0] RATE_SKIP_HI = 7'd127;

  typedef struct packed {
    logic [RATE_BITS-1:0] rates;
    logic [5:0]           ssid_length;
    logic                 channel_seen;
    logic [7:0]           channel_number;
    logic                 rsn_seen;
    ofs_t                 rsn_offset;
    logic [7:0]           rsn_length;
    logic                 region_valid;
  } wiep_sum_t;

  typedef struct packed {
    logic      has_ssid;
    logic [7:0] ssid_byte;
    logic      has_sum;
    wiep_sum_t sum;
  } wiep_entry_t;

endpackage

>>> rtl/wiep_parse.sv
// ----------------------------------------------------------------------------
// wiep_parse
// Element walker: per-frame parse state and the result entry for one byte.
// ----------------------------------------------------------------------------
module wiep_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 carries_byte,
  input  logic                 end_of_region,
  output wiep_pkg::wiep_entry_t entry,
  output logic                 push
);

  typedef enum logic [1:0] {PH_ID, PH_LEN, PH_BODY} phase_t;

  wiep_pkg::pos_t                 byte_position, byte_position_next;
  phase_t                         parse_phase, parse_phase_next;
  logic [7:0]                     element_id, element_id_next;
  logic [7:0]                     bytes_left, bytes_left_next;
  logic                           frame_error, frame_error_next;
  logic [wiep_pkg::RATE_BITS-1:0] rate_map, rate_map_next;
  logic [5:0]                     held_ssid_size, held_ssid_size_next;
  logic [7:0]                     held_channel, held_channel_next;
  logic                           held_channel_flag, held_channel_flag_next;
  wiep_pkg::pos_t                 held_rsn_start, held_rsn_start_next;
  logic [7:0]                     held_rsn_size, held_rsn_size_next;
  logic                           held_rsn_flag, held_rsn_flag_next;

  logic       emit;
  logic       len_ok;
  logic       valid_now;
  logic [6:0] rate_idx;

  assign rate_idx = data_byte[6:0];

  always_comb begin
    byte_position_next     = byte_position;
    parse_phase_next       = parse_phase;
    element_id_next        = element_id;
    bytes_left_next        = bytes_left;
    frame_error_next       = frame_error;
    rate_map_next          = rate_map;
    held_ssid_size_next    = held_ssid_size;
    held_channel_next      = held_channel;
    held_channel_flag_next = held_channel_flag;
    held_rsn_start_next    = held_rsn_start;
    held_rsn_size_next     = held_rsn_size;
    held_rsn_flag_next     = held_rsn_flag;
    emit                   = 1'b0;
    len_ok                 = 1'b1;

    if (carries_byte && !frame_error) begin
      if (byte_position >= wiep_pkg::REGION_LIMIT) begin
        frame_error_next = 1'b1;
      end else begin
        byte_position_next = byte_position + wiep_pkg::pos_t'(1);
        case (parse_phase)
          PH_ID: begin
            element_id_next  = data_byte;
            parse_phase_next = PH_LEN;
          end
          PH_LEN: begin
            case (element_id)
              wiep_pkg::EID_SSID: begin
                if (data_byte > wiep_pkg::SSID_MAX_LEN) begin
                  len_ok = 1'b0;
                end else begin
                  held_ssid_size_next = data_byte[5:0];
                end
              end
              wiep_pkg::EID_CHANNEL: len_ok = (data_byte == wiep_pkg::CHANNEL_LEN);
              wiep_pkg::EID_RATES:   len_ok = (data_byte <= wiep_pkg::RATES_MAX_LEN);
              wiep_pkg::EID_RSN: begin
                held_rsn_start_next = byte_position_next;
                held_rsn_size_next  = data_byte;
                held_rsn_flag_next  = 1'b1;
              end
              default: ;
            endcase
            if (!len_ok) begin
              frame_error_next = 1'b1;
            end else begin
              bytes_left_next  = data_byte;
              parse_phase_next = (data_byte == 8'd0) ? PH_ID : PH_BODY;
            end
          end
          PH_BODY: begin
            case (element_id)
              wiep_pkg::EID_SSID: emit = 1'b1;
              wiep_pkg::EID_CHANNEL: begin
                held_channel_next      = data_byte;
                held_channel_flag_next = 1'b1;
              end
              wiep_pkg::EID_RATES, wiep_pkg::EID_EXT_RATES: begin
                if (rate_idx != wiep_pkg::RATE_SKIP_LO && rate_idx != wiep_pkg::RATE_SKIP_HI) begin
                  rate_map_next[rate_idx] = 1'b1;
                end
              end
              default: ;
            endcase
            bytes_left_next = bytes_left - 8'd1;
            if (bytes_left_next == 8'd0) begin
              parse_phase_next = PH_ID;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // summary reflects the state after this item's byte
  assign valid_now = !frame_error_next && (parse_phase_next == PH_ID);

  always_comb begin
    entry.has_ssid  = emit;
    entry.ssid_byte = data_byte;
    entry.has_sum   = end_of_region;
    entry.sum       = '0;
    if (valid_now) begin
      entry.sum.rates          = rate_map_next;
      entry.sum.ssid_length    = held_ssid_size_next;
      entry.sum.channel_seen   = held_channel_flag_next;
      entry.sum.channel_number = held_channel_next;
      entry.sum.rsn_seen       = held_rsn_flag_next;
      entry.sum.rsn_offset     = wiep_pkg::ofs_t'(held_rsn_start_next);
      entry.sum.rsn_length     = held_rsn_size_next;
      entry.sum.region_valid   = 1'b1;
    end
  end

  assign push = take && (emit || end_of_region);

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_region)) begin
      byte_position     <= '0;
      parse_phase       <= PH_ID;
      element_id        <= '0;
      bytes_left        <= '0;
      frame_error       <= 1'b0;
      rate_map          <= '0;
      held_ssid_size    <= '0;
      held_channel      <= '0;
      held_channel_flag <= 1'b0;
      held_rsn_start    <= '0;
      held_rsn_size     <= '0;
      held_rsn_flag     <= 1'b0;
    end else if (take) begin
      byte_position     <= byte_position_next;
      parse_phase       <= parse_phase_next;
      element_id        <= element_id_next;
      bytes_left        <= bytes_left_next;
      frame_error       <= frame_error_next;
      rate_map          <= rate_map_next;
      held_ssid_size    <= held_ssid_size_next;
      held_channel      <= held_channel_next;
      held_channel_flag <= held_channel_flag_next;
      held_rsn_start    <= held_rsn_start_next;
      held_rsn_size     <= held_rsn_size_next;
      held_rsn_flag     <= held_rsn_flag_next;
    end
  end

endmodule

>>> rtl/wifi_information_element_parser_core.sv
// ----------------------------------------------------------------------------
// wifi_information_element_parser_core
// Takes one information-element byte per cycle and walks the id, length,
// body elements of the region. Each input transfer is parsed in the cycle
// it is taken and its results are written into a four-entry result queue;
// SSID body bytes come out as they arrive and the last item of a region
// gives a summary of rates, SSID length, channel and RSN placement. Input
// is taken every cycle while the queue has room; an item that closes a
// region and also carries an SSID byte gives two results and holds its
// queue entry for two output transfers. Parse state clears after each
// summary, so frames follow each other with no gap.
// ----------------------------------------------------------------------------
module wifi_information_element_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        carries_byte,
  input  logic        end_of_region,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_summary,
  output logic [7:0]  ssid_byte,
  output logic [63:0] rates_low,
  output logic [61:0] rates_high,
  output logic [5:0]  ssid_length,
  output logic        channel_seen,
  output logic [7:0]  channel_number,
  output logic        rsn_seen,
  output logic [11:0] rsn_offset,
  output logic [7:0]  rsn_length,
  output logic        region_valid,
  output logic        last_of_run
);

  wiep_pkg::wiep_entry_t entry;
  wiep_pkg::wiep_entry_t head;
  wiep_pkg::wiep_entry_t fifo_mem [wiep_pkg::FIFO_DEPTH];

  logic [wiep_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [wiep_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [wiep_pkg::FIFO_CNT_W-1:0] count;
  logic                            sum_phase;

  logic in_xfer;
  logic push;
  logic out_xfer;
  logic pop;
  logic sum_out;

  assign in_stall = (count == wiep_pkg::FIFO_CNT_W'(wiep_pkg::FIFO_DEPTH));
  assign in_xfer  = in_valid && !in_stall;

  wiep_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .take          (in_xfer),
    .data_byte     (data_byte),
    .carries_byte  (carries_byte),
    .end_of_region (end_of_region),
    .entry         (entry),
    .push          (push)
  );

  assign head      = fifo_mem[rd_ptr];
  assign out_valid = (count != '0);
  assign sum_out   = !head.has_ssid || sum_phase;
  assign out_xfer  = out_valid && !out_stall;
  assign pop       = out_xfer && (sum_out || !head.has_sum);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      sum_phase <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wiep_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wiep_pkg::FIFO_PTR_W'(1);
      end
      count <= count + wiep_pkg::FIFO_CNT_W'(push) - wiep_pkg::FIFO_CNT_W'(pop);
      if (out_xfer) begin
        sum_phase <= !pop;
      end
    end
  end

  always_comb begin
    is_summary     = sum_out;
    ssid_byte      = sum_out ? 8'd0 : head.ssid_byte;
    rates_low      = sum_out ? head.sum.rates[63:0] : 64'd0;
    rates_high     = sum_out ? head.sum.rates[wiep_pkg::RATE_BITS-1:64] : 62'd0;
    ssid_length    = sum_out ? head.sum.ssid_length : 6'd0;
    channel_seen   = sum_out && head.sum.channel_seen;
    channel_number = sum_out ? head.sum.channel_number : 8'd0;
    rsn_seen       = sum_out && head.sum.rsn_seen;
    rsn_offset     = sum_out ? head.sum.rsn_offset : 12'd0;
    rsn_length     = sum_out ? head.sum.rsn_length : 8'd0;
    region_valid   = sum_out && head.sum.region_valid;
    last_of_run    = sum_out || !head.has_sum;
  end

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= wiep_pkg::FIFO_CNT_W'(wiep_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  // second half of a two-result entry only on an entry that has both
  a_sum_phase: assert property (@(posedge clk) disable iff (rst)
    sum_phase |-> out_valid && head.has_ssid && head.has_sum)
    else $error("summary phase on a single-result entry");

  // an ssid result that is not last is followed by its summary
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !is_summary && !last_of_run |=> out_valid && is_summary)
    else $error("summary did not follow its ssid byte");

  // a failed region reports no held values
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_summary && !region_valid |->
      rates_low == 64'd0 && rates_high == 62'd0 && ssid_length == 6'd0 && !rsn_seen)
    else $error("invalid summary carries data");

endmodule
